>>> src/avrdec_pkg.sv
// Shared types, class codes and result packing for the AVR subset decoder.
package avrdec_pkg;

    localparam int unsigned WORD_W  = 16;
    localparam int unsigned CLASS_W = 4;
    localparam int unsigned REG_W   = 5;
    localparam int unsigned IMM_W   = 8;
    localparam int unsigned BOFF_W  = 7;
    localparam int unsigned IO_W    = 6;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned RES_W   = CLASS_W + 2 * REG_W + IMM_W + BOFF_W + IO_W + MODE_W;
    localparam int unsigned RES_BYTES_W = ((RES_W + 7) / 8) * 8;

    localparam logic [CLASS_W-1:0] CLS_NOP     = 4'd0;
    localparam logic [CLASS_W-1:0] CLS_EOR     = 4'd1;
    localparam logic [CLASS_W-1:0] CLS_LDI     = 4'd2;
    localparam logic [CLASS_W-1:0] CLS_LD      = 4'd3;
    localparam logic [CLASS_W-1:0] CLS_CPI     = 4'd4;
    localparam logic [CLASS_W-1:0] CLS_BRNE    = 4'd5;
    localparam logic [CLASS_W-1:0] CLS_SBIW    = 4'd6;
    localparam logic [CLASS_W-1:0] CLS_CP      = 4'd7;
    localparam logic [CLASS_W-1:0] CLS_MOV     = 4'd8;
    localparam logic [CLASS_W-1:0] CLS_OUT     = 4'd9;
    localparam logic [CLASS_W-1:0] CLS_DEC     = 4'd10;
    localparam logic [CLASS_W-1:0] CLS_INC     = 4'd11;
    localparam logic [CLASS_W-1:0] CLS_UNKNOWN = 4'd12;

    localparam logic [MODE_W-1:0] LD_X_POSTINC = 2'd0;
    localparam logic [MODE_W-1:0] LD_X_PREDEC  = 2'd1;
    localparam logic [MODE_W-1:0] LD_Y_POSTINC = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]        ld_mode;
        logic [IO_W-1:0]          io_address;
        logic signed [BOFF_W-1:0] branch_offset;
        logic [IMM_W-1:0]         immediate;
        logic [REG_W-1:0]         src_reg;
        logic [REG_W-1:0]         dest_reg;
        logic [CLASS_W-1:0]       op_class;
    } t_dec_result;

    // Struct layout already puts op_class lowest; pad to whole bytes.
    function automatic logic [RES_BYTES_W-1:0] pack_result(input t_dec_result res);
        logic [RES_BYTES_W-1:0] v;
        v = '0;
        v[RES_W-1:0] = res;
        return v;
    endfunction

endpackage

>>> src/avrdec_decode.sv
// Combinational pattern match and operand extraction for one instruction word.
module avrdec_decode
    import avrdec_pkg::*;
(
    input  logic [WORD_W-1:0] i_word,
    output t_dec_result       o_res
);

    logic [5:0] top6;
    logic [3:0] top4;
    logic [6:0] top7;
    logic [7:0] top8;
    logic [4:0] top5;
    logic [3:0] low4;
    logic [4:0] d5;
    logic [4:0] r5;

    assign top6 = i_word[15:10];
    assign top4 = i_word[15:12];
    assign top7 = i_word[15:9];
    assign top8 = i_word[15:8];
    assign top5 = i_word[15:11];
    assign low4 = i_word[3:0];
    assign d5   = i_word[8:4];
    assign r5   = {i_word[9], i_word[3:0]};

    always_comb begin
        o_res          = '0;
        o_res.op_class = CLS_UNKNOWN;
        if (i_word == '0) begin
            o_res.op_class = CLS_NOP;
        end else if (top6 == 6'h09) begin
            o_res.op_class = CLS_EOR;
            o_res.dest_reg = d5;
            o_res.src_reg  = r5;
        end else if (top4 == 4'hE || top4 == 4'h3) begin
            o_res.op_class  = (top4 == 4'hE) ? CLS_LDI : CLS_CPI;
            o_res.dest_reg  = {1'b1, i_word[7:4]};
            o_res.immediate = {i_word[11:8], low4};
        end else if (top7 == 7'h48) begin
            // unlisted pointer modes fall to unknown with no later match
            if (low4 == 4'hD) begin
                o_res.op_class = CLS_LD;
                o_res.dest_reg = d5;
                o_res.ld_mode  = LD_X_POSTINC;
            end else if (low4 == 4'hE) begin
                o_res.op_class = CLS_LD;
                o_res.dest_reg = d5;
                o_res.ld_mode  = LD_X_PREDEC;
            end else if (low4 == 4'h9) begin
                o_res.op_class = CLS_LD;
                o_res.dest_reg = d5;
                o_res.ld_mode  = LD_Y_POSTINC;
            end
        end else if (top6 == 6'h3D && i_word[2:0] == 3'b001) begin
            o_res.op_class      = CLS_BRNE;
            o_res.branch_offset = i_word[9:3];
        end else if (top8 == 8'h97) begin
            o_res.op_class  = CLS_SBIW;
            o_res.dest_reg  = {2'b11, i_word[5:4], 1'b0};
            o_res.immediate = {2'b00, i_word[7:6], low4};
        end else if (top6 == 6'h05) begin
            o_res.op_class = CLS_CP;
            o_res.dest_reg = d5;
            o_res.src_reg  = r5;
        end else if (top6 == 6'h0B) begin
            o_res.op_class = CLS_MOV;
            o_res.dest_reg = d5;
            o_res.src_reg  = r5;
        end else if (top5 == 5'h17) begin
            o_res.op_class   = CLS_OUT;
            o_res.src_reg    = d5;
            o_res.io_address = {i_word[10:9], low4};
        end else if (top7 == 7'h4A) begin
            if (low4 == 4'hA) begin
                o_res.op_class = CLS_DEC;
                o_res.dest_reg = d5;
            end else if (low4 == 4'h3) begin
                o_res.op_class = CLS_INC;
                o_res.dest_reg = d5;
            end
        end
    end

endmodule

>>> src/avr_subset_instruction_decoder_core.sv
// Top level: input register, decode logic and result register of the AVR subset decoder.
//
//  channel  | dir | handshake              | payload
//  s_axis   | in  | i_s_axis_tvalid/o_..   | tdata[15:0] instr_word
//  m_axis   | out | o_m_axis_tvalid/i_..   | tdata[39:0] decoded fields, 3 pad bits
//
// One word per cycle sustained while m_axis does not stall; each request passes through
// the input register, then the decode logic, then the result register.
// Reset (i_rst_n low, synchronous) empties both registers; payload is not cleared.
// A stall on m_axis holds the result; the input register still takes a request
// while the result register waits, then stalls once it is full too.
module avr_subset_instruction_decoder_core
    import avrdec_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [WORD_W-1:0]      i_s_axis_tdata,  // [15:0] instr_word
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [3:0] op_class, [8:4] dest_reg, [13:9] src_reg, [21:14] immediate,
    // [28:22] branch_offset, [34:29] io_address, [36:35] ld_mode, [39:37] zero
    output logic [RES_BYTES_W-1:0] o_m_axis_tdata
);

    logic              r_in_valid;
    logic              n_in_valid;
    logic [WORD_W-1:0] r_in_word;
    logic              r_out_valid;
    logic              n_out_valid;
    t_dec_result       r_out;
    t_dec_result       dec_res;
    logic              in_take;
    logic              out_free;
    logic              in_adv;

    avrdec_decode u_decode (
        .i_word (r_in_word),
        .o_res  (dec_res)
    );

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign in_adv          = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || in_adv;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (in_adv) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (in_adv) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_s_axis_tdata;
        end
        if (in_adv) begin
            r_out <= dec_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = pack_result(r_out);

    a_unknown_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.op_class == CLS_UNKNOWN) |->
            (r_out.dest_reg == '0 && r_out.src_reg == '0 && r_out.immediate == '0 &&
             r_out.branch_offset == '0 && r_out.io_address == '0 && r_out.ld_mode == '0))
        else $error("unknown result carries nonzero fields");

    a_mode_only_ld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.op_class != CLS_LD) |-> (r_out.ld_mode == '0))
        else $error("ld_mode set on a non-LD result");

    a_high_regs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.op_class == CLS_LDI || r_out.op_class == CLS_CPI ||
                         r_out.op_class == CLS_SBIW)) |-> r_out.dest_reg[4])
        else $error("immediate-class destination below r16");

    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_adv |=> r_out_valid)
        else $error("decoded word lost between stages");

    a_take_fills_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_in_valid)
        else $error("accepted request not held in input register");

endmodule
